@@ src/aob_pkg.sv @@
// shared types and constants for the alpha over blend pipeline
`default_nettype none

package aob_pkg;

   localparam int unsigned ChanWidth  = 8;
   localparam int unsigned WeightWidth = 16;
   localparam int unsigned NumWidth   = 24;
   localparam int unsigned NumColors  = 3;
   localparam int unsigned QuoBits    = 8;
   localparam int unsigned AlphaWidth = 16;
   localparam int unsigned AlphaShWidth = 15;

   localparam logic [ChanWidth-1:0] FullScale = 8'd255;
   // alpha divisor 255 pre-shifted to the first quotient bit
   localparam logic [AlphaShWidth-1:0] AlphaDivInit = 15'd32640;

   typedef logic [ChanWidth-1:0] chan_type;

   typedef struct packed {
      logic                                       valid;
      logic                                       zero;
      logic [NumColors-1:0][NumWidth-1:0]         rem;
      logic [NumWidth-1:0]                        den_sh;
      logic [NumColors-1:0][QuoBits-1:0]          quo;
      logic [AlphaWidth-1:0]                      alp_rem;
      logic [AlphaShWidth-1:0]                    alp_sh;
      logic [QuoBits-1:0]                         alp_quo;
   } div_type;

endpackage

`default_nettype wire

@@ src/aob_front.sv @@
// weight, product and numerator stages ahead of the dividers
`default_nettype none

module aob_front (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        in_valid,
   input  wire aob_pkg::chan_type [aob_pkg::NumColors-1:0]  top_color,
   input  wire aob_pkg::chan_type                           top_alpha,
   input  wire aob_pkg::chan_type [aob_pkg::NumColors-1:0]  bot_color,
   input  wire aob_pkg::chan_type                           bot_alpha,
   output aob_pkg::div_type                                 div_out
);

   localparam int unsigned NC = aob_pkg::NumColors;
   localparam int unsigned WW = aob_pkg::WeightWidth;
   localparam int unsigned NW = aob_pkg::NumWidth;

   // stage 1: weights
   logic                                   v1_ff;
   logic [WW-1:0]                          wt_ff, wt_in;
   logic [WW-1:0]                          wb_ff, wb_in;
   aob_pkg::chan_type [NC-1:0]             ct1_ff, cb1_ff;

   // stage 2: products and denominator
   logic                                   v2_ff;
   logic [NC-1:0][NW-1:0]                  pt_ff, pt_in;
   logic [NC-1:0][NW-1:0]                  pb_ff, pb_in;
   logic [WW-1:0]                          den2_ff, den2_in;

   // stage 3: numerators
   aob_pkg::div_type                       d3_ff, d3_in;

   always_comb begin
      wt_in = WW'(top_alpha) * WW'(aob_pkg::FullScale);
      wb_in = WW'(bot_alpha) * WW'(aob_pkg::FullScale - top_alpha);
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         pt_in[c] = NW'(ct1_ff[c]) * NW'(wt_ff);
         pb_in[c] = NW'(cb1_ff[c]) * NW'(wb_ff);
      end
      den2_in = wt_ff + wb_ff;
   end

   always_comb begin
      d3_in = '0;
      d3_in.valid = v2_ff;
      d3_in.zero  = (den2_ff == '0);
      for (int c = 0; c < NC; c++) begin
         d3_in.rem[c] = pt_ff[c] + pb_ff[c];
      end
      d3_in.den_sh  = {1'b0, den2_ff, 7'b0};
      d3_in.alp_rem = den2_ff;
      d3_in.alp_sh  = aob_pkg::AlphaDivInit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         d3_ff.valid <= 1'b0;
      end else begin
         v1_ff       <= in_valid;
         v2_ff       <= v1_ff;
         d3_ff.valid <= d3_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      wt_ff   <= wt_in;
      wb_ff   <= wb_in;
      ct1_ff  <= top_color;
      cb1_ff  <= bot_color;
      pt_ff   <= pt_in;
      pb_ff   <= pb_in;
      den2_ff <= den2_in;
      d3_ff.zero    <= d3_in.zero;
      d3_ff.rem     <= d3_in.rem;
      d3_ff.den_sh  <= d3_in.den_sh;
      d3_ff.quo     <= d3_in.quo;
      d3_ff.alp_rem <= d3_in.alp_rem;
      d3_ff.alp_sh  <= d3_in.alp_sh;
      d3_ff.alp_quo <= d3_in.alp_quo;
   end

   assign div_out = d3_ff;

endmodule

`default_nettype wire

@@ src/aob_div_step.sv @@
// one restoring division step for all four lanes, one quotient bit each
`default_nettype none

module aob_div_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire aob_pkg::div_type  step_in,
   output aob_pkg::div_type       step_out
);

   localparam int unsigned NC = aob_pkg::NumColors;
   localparam int unsigned NW = aob_pkg::NumWidth;
   localparam int unsigned AW = aob_pkg::AlphaWidth;
   localparam int unsigned QB = aob_pkg::QuoBits;

   aob_pkg::div_type  st_ff, st_in;
   logic [NW:0]       diff   [NC];
   logic [AW:0]       a_diff;

   always_comb begin
      st_in = step_in;
      for (int c = 0; c < NC; c++) begin
         diff[c] = {1'b0, step_in.rem[c]} - {1'b0, step_in.den_sh};
         if (!diff[c][NW]) begin
            st_in.rem[c] = diff[c][NW-1:0];
         end
         st_in.quo[c] = {step_in.quo[c][QB-2:0], ~diff[c][NW]};
      end
      st_in.den_sh = step_in.den_sh >> 1;

      a_diff = {1'b0, step_in.alp_rem} - {1'b0, AW'(step_in.alp_sh)};
      if (!a_diff[AW]) begin
         st_in.alp_rem = a_diff[AW-1:0];
      end
      st_in.alp_quo = {step_in.alp_quo[QB-2:0], ~a_diff[AW]};
      st_in.alp_sh  = step_in.alp_sh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else begin
         st_ff.valid <= st_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      st_ff.zero    <= st_in.zero;
      st_ff.rem     <= st_in.rem;
      st_ff.den_sh  <= st_in.den_sh;
      st_ff.quo     <= st_in.quo;
      st_ff.alp_rem <= st_in.alp_rem;
      st_ff.alp_sh  <= st_in.alp_sh;
      st_ff.alp_quo <= st_in.alp_quo;
   end

   assign step_out = st_ff;

endmodule

`default_nettype wire

@@ src/alpha_over_blend_core.sv @@
// straight alpha over compositing of two rgba8 pixels, fully pipelined
//
//   channel   ports                    handshake
//   request   start, busy, req_*       beat taken when start high and busy low
//   response  rsp_strobe, rsp_out_*    beat shown for one cycle, no backpressure
//
// one pixel pair per clock while busy is low; 3 stages for weights, products
// and numerators, then 8 restoring divide steps, one quotient bit each
// busy is high only during reset; reset clears the valid bits of every stage
// the receiver cannot stall, so the pipeline never holds
`default_nettype none

module alpha_over_blend_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_top_red,
   input  wire logic [7:0]  req_top_green,
   input  wire logic [7:0]  req_top_blue,
   input  wire logic [7:0]  req_top_alpha,
   input  wire logic [7:0]  req_bottom_red,
   input  wire logic [7:0]  req_bottom_green,
   input  wire logic [7:0]  req_bottom_blue,
   input  wire logic [7:0]  req_bottom_alpha,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic [7:0]       rsp_out_alpha
);

   localparam int unsigned NC = aob_pkg::NumColors;
   localparam int unsigned NSteps = aob_pkg::QuoBits;

   aob_pkg::chan_type [NC-1:0]  top_color, bot_color;
   aob_pkg::div_type            stage [NSteps+1];
   aob_pkg::div_type            last;

   assign busy = reset;

   assign top_color = {req_top_blue, req_top_green, req_top_red};
   assign bot_color = {req_bottom_blue, req_bottom_green, req_bottom_red};

   aob_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .top_color (top_color),
      .top_alpha (req_top_alpha),
      .bot_color (bot_color),
      .bot_alpha (req_bottom_alpha),
      .div_out   (stage[0])
   );

   for (genvar i = 0; i < NSteps; i++) begin : g_div
      aob_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .step_in  (stage[i]),
         .step_out (stage[i+1])
      );
   end

   assign last = stage[NSteps];

   // both alphas zero gives a zero denominator: colours forced to zero
   assign rsp_strobe    = last.valid;
   assign rsp_out_red   = last.zero ? '0 : last.quo[0];
   assign rsp_out_green = last.zero ? '0 : last.quo[1];
   assign rsp_out_blue  = last.zero ? '0 : last.quo[2];
   assign rsp_out_alpha = last.alp_quo;

endmodule

`default_nettype wire

@@ test/tb_alpha_over_blend_core.sv @@
// self-checking testbench for the straight alpha over blend core
`timescale 1ns / 100ps

module tb_alpha_over_blend_core;

   localparam int unsigned RandomPairs = 1630;
   localparam int unsigned QuietLimit  = 1000;
   localparam int unsigned TailCycles  = 24;

   typedef struct packed {
      aob_pkg::chan_type red;
      aob_pkg::chan_type green;
      aob_pkg::chan_type blue;
      aob_pkg::chan_type alpha;
   } rgba_type;

   typedef struct {
      rgba_type    top;
      rgba_type    bottom;
      int unsigned gap;    // idle cycles ahead of this beat
      bit          drain;  // hold this beat until every blend is out
   } beat_type;

   typedef enum int unsigned {PaceBurst, PaceRandom, PaceSparse} pace_type;

   logic              clock;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic              busy;
   aob_pkg::chan_type req_top_red      = '0;
   aob_pkg::chan_type req_top_green    = '0;
   aob_pkg::chan_type req_top_blue     = '0;
   aob_pkg::chan_type req_top_alpha    = '0;
   aob_pkg::chan_type req_bottom_red   = '0;
   aob_pkg::chan_type req_bottom_green = '0;
   aob_pkg::chan_type req_bottom_blue  = '0;
   aob_pkg::chan_type req_bottom_alpha = '0;
   logic              rsp_strobe;
   aob_pkg::chan_type rsp_out_red;
   aob_pkg::chan_type rsp_out_green;
   aob_pkg::chan_type rsp_out_blue;
   aob_pkg::chan_type rsp_out_alpha;

   beat_type    pending_beats[$];
   rgba_type    blend_expect[$];
   beat_type    staged_beat;
   bit          staged   = 1'b0;
   bit          offering = 1'b0;
   int unsigned idle_left = 0;
   int unsigned results_outstanding = 0;
   int unsigned quiet_cycles = 0;
   int unsigned error_count = 0;
   int unsigned pairs_taken = 0;
   int unsigned results_checked = 0;
   int unsigned clear_pairs = 0;
   int unsigned opaque_tops = 0;
   rgba_type    want_pixel;

   alpha_over_blend_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_top_red      (req_top_red),
      .req_top_green    (req_top_green),
      .req_top_blue     (req_top_blue),
      .req_top_alpha    (req_top_alpha),
      .req_bottom_red   (req_bottom_red),
      .req_bottom_green (req_bottom_green),
      .req_bottom_blue  (req_bottom_blue),
      .req_bottom_alpha (req_bottom_alpha),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // exact integer over operator, quotients truncated
   function automatic rgba_type composite_over(rgba_type top, rgba_type bottom);
      logic [31:0] top_weight;
      logic [31:0] bottom_weight;
      logic [31:0] coverage;
      rgba_type    mixed;
      top_weight    = 32'(top.alpha) * 32'(aob_pkg::FullScale);
      bottom_weight = 32'(bottom.alpha) * (32'(aob_pkg::FullScale) - 32'(top.alpha));
      coverage      = top_weight + bottom_weight;
      mixed.alpha   = aob_pkg::chan_type'(coverage / 32'(aob_pkg::FullScale));
      if (coverage == 0) begin
         mixed.red   = '0;
         mixed.green = '0;
         mixed.blue  = '0;
      end else begin
         mixed.red   = aob_pkg::chan_type'((32'(top.red) * top_weight
                                   + 32'(bottom.red) * bottom_weight) / coverage);
         mixed.green = aob_pkg::chan_type'((32'(top.green) * top_weight
                                   + 32'(bottom.green) * bottom_weight) / coverage);
         mixed.blue  = aob_pkg::chan_type'((32'(top.blue) * top_weight
                                   + 32'(bottom.blue) * bottom_weight) / coverage);
      end
      return mixed;
   endfunction

   function automatic aob_pkg::chan_type random_channel();
      unique case ($urandom_range(0, 7))
         0: return aob_pkg::chan_type'(0);
         1: return aob_pkg::FullScale;
         default: return aob_pkg::chan_type'($urandom);
      endcase
   endfunction

   // alpha leans on the edges where the weights degenerate
   function automatic aob_pkg::chan_type random_alpha();
      unique case ($urandom_range(0, 9))
         0: return aob_pkg::chan_type'(0);
         1: return aob_pkg::FullScale;
         2: return aob_pkg::chan_type'(1);
         3: return aob_pkg::FullScale - aob_pkg::chan_type'(1);
         default: return aob_pkg::chan_type'($urandom);
      endcase
   endfunction

   function automatic rgba_type random_rgba();
      rgba_type pixel;
      pixel.red   = random_channel();
      pixel.green = random_channel();
      pixel.blue  = random_channel();
      pixel.alpha = random_alpha();
      return pixel;
   endfunction

   task automatic queue_pair(rgba_type top, rgba_type bottom, int unsigned gap,
                             bit drain);
      beat_type beat;
      beat.top    = top;
      beat.bottom = bottom;
      // a drain never has a zero gap, so the count of open blends is current
      beat.gap    = (drain && gap == 0) ? 1 : gap;
      beat.drain  = drain;
      pending_beats.push_back(beat);
   endtask

   task automatic check_channel(string field, aob_pkg::chan_type want,
                                aob_pkg::chan_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) offering = 1'b0;
         if (!offering && !staged && pending_beats.size() != 0) begin
            staged_beat = pending_beats.pop_front();
            staged      = 1'b1;
            idle_left   = staged_beat.gap;
         end
         if (!offering && staged) begin
            if (idle_left != 0) begin
               idle_left--;
            end else if (!staged_beat.drain || results_outstanding == 0) begin
               offering = 1'b1;
               staged   = 1'b0;
               req_top_red      <= staged_beat.top.red;
               req_top_green    <= staged_beat.top.green;
               req_top_blue     <= staged_beat.top.blue;
               req_top_alpha    <= staged_beat.top.alpha;
               req_bottom_red   <= staged_beat.bottom.red;
               req_bottom_green <= staged_beat.bottom.green;
               req_bottom_blue  <= staged_beat.bottom.blue;
               req_bottom_alpha <= staged_beat.bottom.alpha;
            end
         end
         start <= offering;
      end
   end

   // monitor: check the result beat first, then record the request beat
   always @(posedge clock) begin
      if (reset) begin
         results_outstanding <= 0;
      end else begin
         if (rsp_strobe) begin
            if (blend_expect.size() == 0) begin
               $error("result beat with no blend pending: r %0d g %0d b %0d a %0d",
                      rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha);
               error_count++;
            end else begin
               want_pixel = blend_expect.pop_front();
               check_channel("out_red", want_pixel.red, rsp_out_red);
               check_channel("out_green", want_pixel.green, rsp_out_green);
               check_channel("out_blue", want_pixel.blue, rsp_out_blue);
               check_channel("out_alpha", want_pixel.alpha, rsp_out_alpha);
               results_checked++;
            end
         end
         if (start && !busy) begin
            blend_expect.push_back(composite_over(
               rgba_type'{req_top_red, req_top_green, req_top_blue, req_top_alpha},
               rgba_type'{req_bottom_red, req_bottom_green, req_bottom_blue,
                          req_bottom_alpha}));
            pairs_taken++;
            if (req_top_alpha == 0 && req_bottom_alpha == 0) clear_pairs++;
            if (req_top_alpha == aob_pkg::FullScale) opaque_tops++;
         end
         results_outstanding <= blend_expect.size();
      end
   end

   // watchdog on cycles with neither a request nor a result beat
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("tb_alpha_over_blend_core: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      pace_type    pace;
      int unsigned gap;
      pace = PaceBurst;
      gap  = 0;

      // both alphas zero
      queue_pair(rgba_type'{8'd0, 8'd0, 8'd0, 8'd0}, rgba_type'{8'd0, 8'd0, 8'd0, 8'd0},
                 0, 1'b0);
      queue_pair(rgba_type'{8'd255, 8'd255, 8'd255, 8'd0},
                 rgba_type'{8'd255, 8'd255, 8'd255, 8'd0}, 0, 1'b0);
      queue_pair(rgba_type'{8'hAA, 8'h55, 8'h0F, 8'd0},
                 rgba_type'{8'h55, 8'hAA, 8'hF0, 8'd0}, 3, 1'b0);
      // opaque top
      queue_pair(rgba_type'{8'd12, 8'd200, 8'd77, 8'd255},
                 rgba_type'{8'd255, 8'd0, 8'd128, 8'd255}, 0, 1'b0);
      queue_pair(rgba_type'{8'd255, 8'd0, 8'd255, 8'd255},
                 rgba_type'{8'd0, 8'd255, 8'd0, 8'd0}, 0, 1'b0);
      queue_pair(rgba_type'{8'd255, 8'd255, 8'd255, 8'd255},
                 rgba_type'{8'd255, 8'd255, 8'd255, 8'd255}, 1, 1'b0);
      queue_pair(rgba_type'{8'd0, 8'd0, 8'd0, 8'd255},
                 rgba_type'{8'd255, 8'd255, 8'd255, 8'd0}, 0, 1'b0);
      // transparent top
      queue_pair(rgba_type'{8'd255, 8'd255, 8'd255, 8'd0},
                 rgba_type'{8'd1, 8'd2, 8'd3, 8'd255}, 0, 1'b0);
      queue_pair(rgba_type'{8'd9, 8'd99, 8'd199, 8'd0},
                 rgba_type'{8'd200, 8'd100, 8'd50, 8'd77}, 0, 1'b0);
      queue_pair(rgba_type'{8'd0, 8'd0, 8'd0, 8'd0},
                 rgba_type'{8'd255, 8'd128, 8'd1, 8'd1}, 2, 1'b0);
      // near the alpha edges
      queue_pair(rgba_type'{8'd255, 8'd0, 8'd128, 8'd1},
                 rgba_type'{8'd0, 8'd0, 8'd0, 8'd0}, 0, 1'b0);
      queue_pair(rgba_type'{8'd0, 8'd255, 8'd0, 8'd1},
                 rgba_type'{8'd255, 8'd0, 8'd255, 8'd255}, 0, 1'b0);
      queue_pair(rgba_type'{8'd255, 8'd255, 8'd255, 8'd1},
                 rgba_type'{8'd0, 8'd0, 8'd0, 8'd1}, 0, 1'b0);
      queue_pair(rgba_type'{8'd10, 8'd20, 8'd30, 8'd254},
                 rgba_type'{8'd250, 8'd240, 8'd230, 8'd1}, 0, 1'b0);
      queue_pair(rgba_type'{8'd0, 8'd128, 8'd255, 8'd254},
                 rgba_type'{8'd255, 8'd127, 8'd0, 8'd255}, 0, 1'b0);
      queue_pair(rgba_type'{8'd255, 8'd255, 8'd255, 8'd128},
                 rgba_type'{8'd0, 8'd0, 8'd0, 8'd128}, 0, 1'b0);
      queue_pair(rgba_type'{8'd0, 8'd0, 8'd0, 8'd127},
                 rgba_type'{8'd255, 8'd255, 8'd255, 8'd254}, 0, 1'b0);
      queue_pair(rgba_type'{8'h80, 8'h40, 8'h01, 8'h80},
                 rgba_type'{8'h7F, 8'hBF, 8'hFE, 8'h7F}, 0, 1'b0);
      queue_pair(rgba_type'{8'h01, 8'h02, 8'h04, 8'h08},
                 rgba_type'{8'h10, 8'h20, 8'h40, 8'h80}, 0, 1'b0);

      for (int unsigned n = 0; n < RandomPairs; n++) begin
         if (n % 50 == 0) pace = pace_type'($urandom_range(0, 2));
         unique case (pace)
            PaceBurst:  gap = 0;
            PaceRandom: gap = $urandom_range(0, 14);
            default:    gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
         endcase
         // the first random beat and every 400th wait for an empty pipeline
         queue_pair(random_rgba(), random_rgba(), gap, n % 400 == 0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || staged || offering) @(negedge clock);
      while (results_outstanding != 0) @(negedge clock);
      repeat (TailCycles) @(negedge clock);

      if (blend_expect.size() != 0) begin
         $error("%0d blended pixels never came out", blend_expect.size());
         error_count++;
      end
      $display("sent %0d pixel pairs, %0d with both alphas zero, %0d with an opaque top",
               pairs_taken, clear_pairs, opaque_tops);
      $display("checked %0d blended pixels, %0d failures", results_checked, error_count);
      if (error_count == 0) begin
         $display("tb_alpha_over_blend_core: clean");
      end else begin
         $display("tb_alpha_over_blend_core: errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/aob_pkg.sv
src/aob_front.sv
src/aob_div_step.sv
src/alpha_over_blend_core.sv
test/tb_alpha_over_blend_core.sv
